[rtl/deq_pkg.sv]
// Shared constants, codes and types of the double-ended queue unit.
package deq_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam int ACTION_WIDTH = 3;
  localparam int STATUS_WIDTH = 2;

  localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_WIDTH-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_WIDTH-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR      = 3'd4;
  localparam logic [ACTION_WIDTH-1:0] ACT_QUERY      = 3'd5;

  localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW  = 2'd2;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LEFT  = 2'd1,
    CELL_FROM_RIGHT = 2'd2,
    CELL_FROM_PUSH  = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
  } cell_ctrl_t;

endpackage

[rtl/deq_if.sv]
// Valid/ready channel interfaces for the request and result sides.
interface deq_req_if #(
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
);
  logic                                 valid;
  logic                                 ready;
  logic [deq_pkg::ACTION_WIDTH-1:0]     action;
  logic signed [DATA_WIDTH-1:0]         push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface deq_rsp_if #(
  parameter int DATA_WIDTH  = deq_pkg::DATA_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH = $clog2(deq_pkg::DEPTH_DEFAULT + 1)
);
  logic                                 valid;
  logic                                 ready;
  logic signed [DATA_WIDTH-1:0]         front_value;
  logic signed [DATA_WIDTH-1:0]         back_value;
  logic [COUNT_WIDTH-1:0]               element_count;
  logic                                 is_empty;
  logic [deq_pkg::STATUS_WIDTH-1:0]     status;

  modport source (output valid, output front_value, output back_value,
                  output element_count, output is_empty, output status, input ready);
  modport sink   (input valid, input front_value, input back_value,
                  input element_count, input is_empty, input status, output ready);
endinterface

[rtl/double_ended_queue_unit.sv]
// Double-ended queue unit: a shifting row of DEPTH cells with the front in cell 0.
// Timing: the row and status update at the request edge; the result register loads from the
//   updated row when the status stage moves on, once that register is free.
// Throughput: 1 request per cycle while results are taken; a waiting result lets one more
//   request into the status stage, then holds the input until that result transfers.
// Reset (rst, synchronous, active high) empties the queue and drops any pending result.
module double_ended_queue_unit #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  deq_req_if.sink  req,
  deq_rsp_if.source rsp
);
  import deq_pkg::*;

  localparam int CountWidth = $clog2(DEPTH + 1);
  localparam logic [CountWidth-1:0] CountFull = CountWidth'(DEPTH);

  // Row state: cell i holds the element i places behind the front.
  logic [DATA_WIDTH-1:0]   cell_data [DEPTH];
  cell_ctrl_t              cell_ctrl [DEPTH];
  logic [CountWidth-1:0]   count;
  logic [CountWidth-1:0]   count_next;

  // Status stage: one request whose row update is done, result not yet registered.
  logic                    pending;
  logic [STATUS_WIDTH-1:0] status;
  logic [STATUS_WIDTH-1:0] status_next;

  logic                    accept;
  logic                    move;
  logic                    full;
  logic                    empty;
  cell_mode_t              row_mode;
  logic                    back_load_ok;
  logic [DATA_WIDTH-1:0]   push_data;
  logic [DATA_WIDTH-1:0]   back_sel;

  assign full      = (count == CountFull);
  assign empty     = (count == '0);
  assign push_data = $unsigned(req.push_value);

  // Advance the status stage into the result register when that register is free.
  assign move      = pending && (!rsp.valid || rsp.ready);
  assign req.ready = !pending || move;
  assign accept    = req.valid && req.ready;

  // Decode the action: one shift mode for the whole row, plus the targeted back load.
  always_comb begin
    row_mode     = CELL_HOLD;
    back_load_ok = 1'b0;
    count_next   = count;
    status_next  = ST_OK;
    unique case (req.action)
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_OVERFLOW;
        end else begin
          row_mode   = CELL_FROM_LEFT;
          count_next = count + 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          status_next = ST_OVERFLOW;
        end else begin
          back_load_ok = 1'b1;
          count_next   = count + 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_next = ST_UNDERFLOW;
        end else begin
          row_mode   = CELL_FROM_RIGHT;
          count_next = count - 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_next = ST_UNDERFLOW;
        end else begin
          count_next = count - 1'b1;
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
        // Query and the unused codes leave the row alone.
      end
    endcase
  end

  // Per-cell command: only an accepted request moves the row.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (!accept) begin
        cell_ctrl[i].mode = CELL_HOLD;
      end else if (back_load_ok && (count == CountWidth'(i))) begin
        cell_ctrl[i].mode = CELL_FROM_PUSH;
      end else begin
        cell_ctrl[i].mode = row_mode;
      end
    end
  end

  // The row of cells; cell 0 shifts in the push value, the last cell shifts in zero.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_in;
    logic [DATA_WIDTH-1:0] right_in;
    if (g == 0) begin : g_first
      assign left_in = push_data;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end
    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[g]),
      .left_data  (left_in),
      .right_data (right_in),
      .push_value (push_data),
      .data       (cell_data[g])
    );
  end

  // Back value: the cell just before the first free place, picked by a one-hot AND-OR.
  always_comb begin
    back_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_sel = back_sel | (cell_data[i] & {DATA_WIDTH{count == CountWidth'(i + 1)}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      pending <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        pending <= 1'b1;
      end else if (move) begin
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  // Result register: hold until the transfer, load from the updated row on a move.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (move) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      rsp.front_value   <= empty ? '0 : $signed(cell_data[0]);
      rsp.back_value    <= $signed(back_sel);
      rsp.element_count <= count;
      rsp.is_empty      <= empty;
      rsp.status        <= status;
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CountFull)
    else $error("queue count exceeds depth");

  a_no_false_overflow: assert property (@(posedge clk) disable iff (rst)
    accept && !full && (req.action == ACT_PUSH_FRONT || req.action == ACT_PUSH_BACK)
    |=> status != ST_OVERFLOW)
    else $error("overflow reported on a non-full queue");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (req.action == ACT_CLEAR) |=> count == '0)
    else $error("clear left elements behind");

  a_stall_holds_row: assert property (@(posedge clk) disable iff (rst)
    pending && !move |=> pending && $stable(count))
    else $error("row changed while a result was stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.is_empty == (rsp.element_count == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule

[rtl/deq_cell.sv]
// One storage cell of the queue row: holds a value, shifts or loads on command.
module deq_cell #(
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  deq_pkg::cell_ctrl_t   ctrl,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] push_value,
  output logic [DATA_WIDTH-1:0] data
);
  import deq_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ctrl.mode)
      CELL_FROM_LEFT:  data <= left_data;
      CELL_FROM_RIGHT: data <= right_data;
      CELL_FROM_PUSH:  data <= push_value;
      default:         data <= data;
    endcase
  end

endmodule

[tb/tb_double_ended_queue_unit.sv]
// Self-checking testbench of the double-ended queue unit: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_double_ended_queue_unit;
  import deq_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int DATA_WIDTH  = DATA_WIDTH_DEFAULT;
  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

  // Action codes outside the defined set; the block treats them as a query.
  localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_7 = 3'd7;

  // Traffic profiles of the random part.
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;

  localparam int RANDOM_BLOCKS = 23;
  localparam int BLOCK_ITEMS   = 50;
  localparam int IDLE_LIMIT    = 500;
  localparam int TAIL_CYCLES   = 8;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t                   front;
    word_t                   back;
    logic [COUNT_WIDTH-1:0]  count;
    logic                    empty;
    logic [STATUS_WIDTH-1:0] status;
  } deq_view_t;

  typedef struct {
    logic [ACTION_WIDTH-1:0] act;
    word_t                   val;
    int                      reps;
    bit                      fixed;
    deq_view_t               view;
  } stim_row_t;

  logic clk;
  logic rst;

  deq_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
  deq_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) rsp_ch ();

  double_ended_queue_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the ring: front slot index, fill level and slot contents.
  word_t                  shadow_slots [DEPTH];
  logic [3:0]             shadow_head;
  logic [COUNT_WIDTH-1:0] shadow_fill;

  deq_view_t pending_views [$];
  stim_row_t stim_table [$];

  int  mismatches;
  int  items_sent;
  int  views_checked;
  int  refused_pops;
  int  refused_pushes;
  int  idle_cycles;
  int  stall_left;
  bit  steady;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one action to the shadow ring and return what the block should show after it.
  function automatic deq_view_t apply_action(input logic [ACTION_WIDTH-1:0] act,
                                             input word_t val);
    deq_view_t v;
    logic [3:0] tail;
    v.status = ST_OK;
    case (act)
      ACT_PUSH_FRONT: begin
        if (shadow_fill == DEPTH) begin
          v.status = ST_OVERFLOW;
        end else begin
          shadow_head = shadow_head - 4'd1;
          shadow_slots[shadow_head] = val;
          shadow_fill = shadow_fill + 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (shadow_fill == DEPTH) begin
          v.status = ST_OVERFLOW;
        end else begin
          shadow_slots[4'(shadow_head + shadow_fill[3:0])] = val;
          shadow_fill = shadow_fill + 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (shadow_fill == 0) begin
          v.status = ST_UNDERFLOW;
        end else begin
          shadow_head = shadow_head + 4'd1;
          shadow_fill = shadow_fill - 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (shadow_fill == 0) v.status = ST_UNDERFLOW;
        else shadow_fill = shadow_fill - 1'b1;
      end
      ACT_CLEAR: begin
        shadow_head = 4'd0;
        shadow_fill = '0;
      end
      default: ;
    endcase
    // A full ring has fill[3:0] == 0, so head - 1 is still the back slot.
    tail = 4'(shadow_head + shadow_fill[3:0] - 4'd1);
    v.count = shadow_fill;
    v.empty = (shadow_fill == 0);
    v.front = v.empty ? '0 : shadow_slots[shadow_head];
    v.back  = v.empty ? '0 : shadow_slots[tail];
    return v;
  endfunction

  // Mostly no gap, often a short one, now and then a long one; none in steady stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ACTION_WIDTH-1:0] pick_action(input int mix);
    int r;
    int t_pf, t_pb, t_of, t_ob, t_q, t_c;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        t_pf = 40; t_pb = 80; t_of = 88; t_ob = 94; t_q = 97; t_c = 98;
      end
      MIX_DRAIN: begin
        t_pf = 15; t_pb = 30; t_of = 60; t_ob = 90; t_q = 95; t_c = 97;
      end
      default: begin
        t_pf = 22; t_pb = 44; t_of = 66; t_ob = 88; t_q = 93; t_c = 96;
      end
    endcase
    if (r < t_pf) return ACT_PUSH_FRONT;
    if (r < t_pb) return ACT_PUSH_BACK;
    if (r < t_of) return ACT_POP_FRONT;
    if (r < t_ob) return ACT_POP_BACK;
    if (r < t_q)  return ACT_QUERY;
    if (r < t_c)  return ACT_CLEAR;
    return $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(0, 39))
      0:       return '0;
      1:       return '1;
      2:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      3:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input word_t want, input word_t got);
    $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  task automatic add_row(input logic [ACTION_WIDTH-1:0] act, input word_t val, input int reps,
                         input bit fixed, input deq_view_t view);
    stim_row_t row;
    row.act   = act;
    row.val   = val;
    row.reps  = reps;
    row.fixed = fixed;
    row.view  = view;
    stim_table.insert(stim_table.size(), row);
  endtask

  // Offer one request and hold it until the transfer. Called and returning at a falling edge.
  task automatic send_item(input logic [ACTION_WIDTH-1:0] act, input word_t val,
                           input bit fixed, input deq_view_t fixed_view);
    int gap;
    deq_view_t predicted;
    gap = pick_gap();
    // Drop valid only for a real gap, so a back-to-back item keeps it high.
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.push_value <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // Advance the shadow ring even where the row gives its own expectation.
    predicted = apply_action(act, val);
    pending_views.insert(pending_views.size(), fixed ? fixed_view : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  // Result side: stall at random, hold ready high through steady stretches.
  always @(negedge clk) begin
    if (rst || steady) begin
      rsp_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      stall_left   <= pick_gap();
    end
  end

  // Compare every result transfer with the oldest expectation, field by field.
  always @(posedge clk) begin
    deq_view_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_views.size() == 0) begin
        report_mismatch("result with nothing expected", '0, rsp_ch.front_value);
      end else begin
        want = pending_views[0];
        pending_views.delete(0);
        views_checked++;
        if (rsp_ch.front_value !== want.front)
          report_mismatch("front_value", want.front, rsp_ch.front_value);
        if (rsp_ch.back_value !== want.back)
          report_mismatch("back_value", want.back, rsp_ch.back_value);
        if (rsp_ch.element_count !== want.count)
          report_mismatch("element_count", word_t'(want.count), word_t'(rsp_ch.element_count));
        if (rsp_ch.is_empty !== want.empty)
          report_mismatch("is_empty", word_t'(want.empty), word_t'(rsp_ch.is_empty));
        if (rsp_ch.status !== want.status)
          report_mismatch("status", word_t'(want.status), word_t'(rsp_ch.status));
        if (want.status == ST_UNDERFLOW) refused_pops++;
        if (want.status == ST_OVERFLOW)  refused_pushes++;
      end
    end
  end

  // Watchdog: end the run once nothing has moved on either side for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t row;
    int k;
    int mix;

    // Drive every input to a known value before the first edge.
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.action     = ACT_QUERY;
    req_ch.push_value = '0;
    rsp_ch.ready      = 1'b1;
    stall_left        = 0;
    steady            = 1'b0;
    idle_cycles       = 0;
    mismatches        = 0;
    items_sent        = 0;
    views_checked     = 0;
    refused_pops      = 0;
    refused_pushes    = 0;
    shadow_head       = 4'd0;
    shadow_fill       = '0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;

    // Directed table. Expectations typed in only where they are obvious.
    // Empty after reset, then a refused pop.
    add_row(ACT_QUERY,     '0, 1, 1'b1, '{32'd0, 32'd0, 5'd0, 1'b1, ST_OK});
    add_row(ACT_POP_FRONT, '0, 1, 1'b1, '{32'd0, 32'd0, 5'd0, 1'b1, ST_UNDERFLOW});
    // Largest and smallest values at both ends; the front push wraps the head.
    add_row(ACT_PUSH_BACK,  32'h7FFF_FFFF, 1, 1'b1,
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b0, ST_OK});
    add_row(ACT_PUSH_FRONT, 32'h8000_0000, 1, 1'b1,
            '{32'h8000_0000, 32'h7FFF_FFFF, 5'd2, 1'b0, ST_OK});
    // Spare action codes behave as a query.
    add_row(ACT_SPARE_6, 32'hDEAD_BEEF, 1, 1'b0, '0);
    add_row(ACT_SPARE_7, 32'h1234_5678, 1, 1'b0, '0);
    // Fill to the top from both ends.
    add_row(ACT_PUSH_FRONT, 32'h0000_0001, 7, 1'b0, '0);
    add_row(ACT_PUSH_BACK,  32'hFFFF_FFF0, 7, 1'b0, '0);
    // Pushes on a full ring are refused at either end.
    add_row(ACT_PUSH_FRONT, '0, 1, 1'b1,
            '{32'h0000_0007, 32'hFFFF_FFF6, 5'd16, 1'b0, ST_OVERFLOW});
    add_row(ACT_PUSH_BACK,  '1, 1, 1'b1,
            '{32'h0000_0007, 32'hFFFF_FFF6, 5'd16, 1'b0, ST_OVERFLOW});
    add_row(ACT_POP_FRONT, '0, 1, 1'b0, '0);
    add_row(ACT_POP_BACK,  '0, 1, 1'b0, '0);
    // Clear with elements held, refused pop after it, then a fresh push from head zero.
    add_row(ACT_CLEAR,     '0, 1, 1'b1, '{32'd0, 32'd0, 5'd0, 1'b1, ST_OK});
    add_row(ACT_POP_BACK,  '0, 1, 1'b1, '{32'd0, 32'd0, 5'd0, 1'b1, ST_UNDERFLOW});
    add_row(ACT_PUSH_BACK, 32'hA5A5_A5A5, 1, 1'b1,
            '{32'hA5A5_A5A5, 32'hA5A5_A5A5, 5'd1, 1'b0, ST_OK});

    // Hold reset, then release it at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[r]) begin
      row = stim_table[r];
      for (k = 0; k < row.reps; k++)
        send_item(row.act, row.val + word_t'(k), row.fixed, row.view);
    end

    // Random part in blocks with a bias each: fill toward overflow, drain toward
    // underflow, or even. Every fifth block runs with no idling on either side.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      steady = (blk % 5 == 3);
      mix = (blk % 4 == 3) ? $urandom_range(MIX_FILL, MIX_EVEN) : (blk % 3);
      for (k = 0; k < BLOCK_ITEMS; k++)
        send_item(pick_action(mix), pick_value(), 1'b0, '0);
    end
    steady = 1'b0;
    req_ch.valid <= 1'b0;

    // Drain the outstanding results, then watch the tail for stray results.
    wait (pending_views.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d results checked", items_sent, views_checked);
    $display("refused pops on empty: %0d, refused pushes on full: %0d",
             refused_pops, refused_pushes);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
